// ===== rtl/bwd_pkg.sv =====
// Shared types, constants and helper functions for the Bayer window demosaic.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none
package bwd_pkg;

  localparam int DEF_MAX_WIDTH  = 8192;
  localparam int DEF_MAX_HEIGHT = 8192;

  localparam int SAMPLE_W   = 16;
  localparam int DIM_W      = 14;
  localparam int GAIN_W     = 24;
  localparam int ACC_W      = 22;  // 52 * 65535 fits
  localparam int CNT_W      = 5;   // up to 25 taps
  localparam int PROD_W     = ACC_W + GAIN_W;
  localparam int DIVD_W     = PROD_W - 18;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN    = 4'd0,
    REG_MOS_WIDTH  = 4'd1,
    REG_MOS_HEIGHT = 4'd2,
    REG_OUT_WIDTH  = 4'd3,
    REG_OUT_HEIGHT = 4'd4,
    REG_GAIN_RED   = 4'd5,
    REG_GAIN_GREEN = 4'd6,
    REG_GAIN_BLUE  = 4'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SHIFT,
    ST_TAP,
    ST_MUL,
    ST_DIVS,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       rd_issue;
    logic [1:0] rd_k;
    logic       wr_en;
    logic       shift;
    logic       pos_adv;
    logic       tap_en;
    logic [2:0] tap_dy;
    logic [2:0] tap_dx;
    logic       mul_en;
    chan_t      chan;
    logic       div_start;
    logic       res_store;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
  } dp_status_t;

  // colour per pattern, indexed by {row parity, col parity}; 0 red, 1 green, 2 blue
  localparam logic [1:0] COLOUR_TABLE [4][4] = '{
    '{2'd1, 2'd0, 2'd2, 2'd1},
    '{2'd0, 2'd1, 2'd1, 2'd2},
    '{2'd2, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd1}
  };

  function automatic logic [1:0] colour_of(input logic [1:0] pat, input logic [1:0] idx);
    return COLOUR_TABLE[pat][idx];
  endfunction

  function automatic logic [4:0] tap_weight(input logic [2:0] dy, input logic [2:0] dx);
    logic [4:0] w;
    if (dy == 3'd2 && dx == 3'd2) w = 5'd16;
    else if (dy == 3'd2 || dx == 3'd2)
      w = (dy == 3'd1 || dy == 3'd3 || dx == 3'd1 || dx == 3'd3) ? 5'd4 : 5'd1;
    else w = 5'd1;
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bwd_if.sv =====
// Stream and configuration channel interfaces for the Bayer window demosaic.
// Depends on bwd_pkg for payload widths.
`default_nettype none
interface bwd_in_if;
  import bwd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bwd_out_if;
  import bwd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red;
  logic [SAMPLE_W-1:0] green;
  logic [SAMPLE_W-1:0] blue;
  logic                row_end;
  logic                frame_end;
  modport source (output valid, output red, output green, output blue,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input row_end, input frame_end, output ready);
endinterface

interface bwd_cfg_if;
  import bwd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bwd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/bwd_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bwd_pkg for operand widths.
`default_nettype none
module bwd_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bwd_pkg::DIVD_W-1:0] dividend,
  input  wire logic [bwd_pkg::CNT_W-1:0]  divisor,
  output logic      [bwd_pkg::DIVD_W-1:0] quotient,
  output logic                            done
);
  import bwd_pkg::*;
  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dq;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial    = {rem, dq[DIVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVD_W);
        dq    <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        dq  <= {dq[DIVD_W-2:0], fits};
        rem <= fits ? CNT_W'(trial - {1'b0, dvs}) : CNT_W'(trial);
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bwd_ctrl.sv =====
// Sequencing state machine for the Bayer window demosaic.
// Depends on bwd_pkg for the state, command and status types.
`default_nettype none
module bwd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire bwd_pkg::dp_status_t stat,
  output bwd_pkg::dp_cmd_t         cmd
);
  import bwd_pkg::*;

  state_t     state, state_next;
  logic [1:0] rd_k, rd_k_next;
  logic [2:0] dy, dy_next, dx, dx_next;
  chan_t      chan, chan_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_k      <= '0;
      dy        <= '0;
      dx        <= '0;
      chan      <= CH_RED;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_k      <= rd_k_next;
      dy        <= dy_next;
      dx        <= dx_next;
      chan      <= chan_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    rd_k_next      = rd_k;
    dy_next        = dy;
    dx_next        = dx;
    chan_next      = chan;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_k       = rd_k;
    cmd.tap_dy     = dy;
    cmd.tap_dx     = dx;
    cmd.chan       = chan;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          rd_k_next  = '0;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        rd_k_next    = rd_k + 2'd1;
        if (rd_k == 2'd3) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift   = 1'b1;
        cmd.pos_adv = 1'b1;
        dy_next     = '0;
        dx_next     = '0;
        state_next  = stat.emit ? ST_TAP : ST_IDLE;
      end
      ST_TAP: begin
        cmd.tap_en = 1'b1;
        if (dx == 3'd4) begin
          dx_next = '0;
          dy_next = dy + 3'd1;
          if (dy == 3'd4) begin
            chan_next  = CH_RED;
            state_next = ST_MUL;
          end
        end else begin
          dx_next = dx + 3'd1;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.res_store = 1'b1;
          if (chan == CH_BLUE) begin
            state_next = ST_FIN;
          end else begin
            chan_next  = (chan == CH_RED) ? CH_GREEN : CH_BLUE;
            state_next = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/bwd_dp.sv =====
// Datapath: configuration registers, grid position, line store, 5x5 window,
// tap accumulation, gain multiply and division. Depends on bwd_pkg, bwd_ram, bwd_div.
`default_nettype none
module bwd_dp #(
  parameter int MAX_WIDTH  = bwd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bwd_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bwd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [bwd_pkg::SAMPLE_W-1:0]   sample,
  input  wire bwd_pkg::dp_cmd_t               cmd,
  output bwd_pkg::dp_status_t                 stat,
  output logic      [bwd_pkg::SAMPLE_W-1:0]   red,
  output logic      [bwd_pkg::SAMPLE_W-1:0]   green,
  output logic      [bwd_pkg::SAMPLE_W-1:0]   blue,
  output logic                                row_end,
  output logic                                frame_end
);
  import bwd_pkg::*;

  localparam int CPW   = $clog2(MAX_WIDTH + 3);
  localparam int RPW   = $clog2(MAX_HEIGHT + 3);
  localparam int DEPTH = 4 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [1:0]        pattern;
  logic [DIM_W-1:0]  mosaic_width, mosaic_height, out_width, out_height;
  logic [GAIN_W-1:0] gain_red, gain_green, gain_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern       <= '0;
      mosaic_width  <= DIM_W'(8192);
      mosaic_height <= DIM_W'(8192);
      out_width     <= DIM_W'(8192);
      out_height    <= DIM_W'(8192);
      gain_red      <= GAIN_W'(65536);
      gain_green    <= GAIN_W'(65536);
      gain_blue     <= GAIN_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN:    pattern       <= cfg_data[1:0];
        REG_MOS_WIDTH:  mosaic_width  <= cfg_data[DIM_W-1:0];
        REG_MOS_HEIGHT: mosaic_height <= cfg_data[DIM_W-1:0];
        REG_OUT_WIDTH:  out_width     <= cfg_data[DIM_W-1:0];
        REG_OUT_HEIGHT: out_height    <= cfg_data[DIM_W-1:0];
        REG_GAIN_RED:   gain_red      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_GREEN: gain_green    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_BLUE:  gain_blue     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [CPW-1:0]   mw, gw, ow;
  logic [RPW-1:0]   mh, gh, oh;
  logic [DIM_W-1:0] ow_raw, oh_raw;

  always_comb begin
    if (mosaic_width == '0) mw = CPW'(1);
    else if (32'(mosaic_width) > 32'(MAX_WIDTH)) mw = CPW'(MAX_WIDTH);
    else mw = CPW'(mosaic_width);
    if (mosaic_height == '0) mh = RPW'(1);
    else if (32'(mosaic_height) > 32'(MAX_HEIGHT)) mh = RPW'(MAX_HEIGHT);
    else mh = RPW'(mosaic_height);
    ow_raw = (out_width == '0) ? DIM_W'(1) : out_width;
    oh_raw = (out_height == '0) ? DIM_W'(1) : out_height;
    ow = (32'(ow_raw) > 32'(mw)) ? mw : CPW'(ow_raw);
    oh = (32'(oh_raw) > 32'(mh)) ? mh : RPW'(oh_raw);
    gw = mw + CPW'(2);
    gh = mh + RPW'(2);
  end

  // grid position, wrapped when the grid shrank
  logic [RPW-1:0] row_position, cur_r, wr0, wr;
  logic [CPW-1:0] col_position, cur_c, wc;
  logic [SAMPLE_W-1:0] cur_sample;

  always_comb begin
    wc  = (col_position >= gw) ? '0 : col_position;
    wr0 = (col_position >= gw) ? row_position + RPW'(1) : row_position;
    wr  = (wr0 >= gh) ? '0 : wr0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      col_position <= '0;
    end else if (cmd.accept) begin
      row_position <= wr;
      col_position <= wc;
    end else if (cmd.pos_adv) begin
      if (cur_c + CPW'(1) >= gw) begin
        col_position <= '0;
        row_position <= (cur_r + RPW'(1) >= gh) ? '0 : cur_r + RPW'(1);
      end else begin
        col_position <= cur_c + CPW'(1);
        row_position <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r      <= wr;
      cur_c      <= wc;
      cur_sample <= sample;
    end
  end

  // line store
  logic           in_mosaic;
  logic [RPW:0]   r_plus_k;
  logic           rd_ok;
  logic [AW-1:0]  raddr, waddr;
  logic [SAMPLE_W-1:0] rdata;
  logic           rd_v_d, rd_ok_d;
  logic [1:0]     rd_k_d;
  logic [SAMPLE_W-1:0] col_new [4];

  assign in_mosaic = (cur_r < mh) && (cur_c < mw);
  assign r_plus_k  = {1'b0, cur_r} + (RPW+1)'(cmd.rd_k);
  assign rd_ok     = (cur_c < mw) && (r_plus_k >= (RPW+1)'(4));
  assign raddr     = rd_ok ? AW'(int'(r_plus_k[1:0]) * MAX_WIDTH + int'(cur_c)) : '0;
  assign waddr     = in_mosaic ? AW'(int'(cur_r[1:0]) * MAX_WIDTH + int'(cur_c)) : '0;

  bwd_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_lines (
    .clk   (clk),
    .we    (cmd.wr_en && in_mosaic),
    .waddr (waddr),
    .wdata (cur_sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) rd_v_d <= 1'b0;
    else     rd_v_d <= cmd.rd_issue;
    rd_k_d  <= cmd.rd_k;
    rd_ok_d <= rd_ok;
    if (rd_v_d) col_new[rd_k_d] <= rd_ok_d ? rdata : '0;
  end

  // 5x5 window
  logic [SAMPLE_W-1:0] win [5][5];

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int y = 0; y < 5; y++)
        for (int x = 0; x < 4; x++)
          win[y][x] <= win[y][x+1];
      for (int k = 0; k < 4; k++)
        win[k][4] <= col_new[k];
      win[4][4] <= in_mosaic ? cur_sample : '0;
    end
  end

  // emit decision and row/frame flags
  logic [RPW-1:0] pos_y;
  logic [CPW-1:0] pos_x;
  logic           emit_now, div_fin;
  assign pos_y    = cur_r - RPW'(2);
  assign pos_x    = cur_c - CPW'(2);
  assign emit_now = (cur_r >= RPW'(2)) && (cur_c >= CPW'(2)) && (pos_y < oh) && (pos_x < ow);
  assign stat     = '{emit: emit_now, div_done: div_fin};

  // tap accumulation
  logic [RPW:0]   tap_r;
  logic [CPW:0]   tap_c;
  logic           tap_ok;
  logic [1:0]     tap_col;
  logic [ACC_W-1:0] tap_val;
  logic [ACC_W-1:0] acc [3];
  logic [CNT_W-1:0] cnt [3];

  always_comb begin
    tap_r   = {1'b0, cur_r} + (RPW+1)'(cmd.tap_dy);
    tap_c   = {1'b0, cur_c} + (CPW+1)'(cmd.tap_dx);
    tap_ok  = (tap_r >= (RPW+1)'(4)) && (tap_r < {1'b0, mh} + (RPW+1)'(4))
           && (tap_c >= (CPW+1)'(4)) && (tap_c < {1'b0, mw} + (CPW+1)'(4));
    tap_col = colour_of(pattern, {cur_r[0] ^ cmd.tap_dy[0], cur_c[0] ^ cmd.tap_dx[0]});
    tap_val = ACC_W'(win[cmd.tap_dy][cmd.tap_dx]) * ACC_W'(tap_weight(cmd.tap_dy, cmd.tap_dx));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int j = 0; j < 3; j++) begin
        acc[j] <= '0;
        cnt[j] <= '0;
      end
    end else if (cmd.tap_en && tap_ok) begin
      case (tap_col)
        CH_RED: begin
          acc[CH_RED] <= acc[CH_RED] + tap_val; cnt[CH_RED] <= cnt[CH_RED] + CNT_W'(1);
        end
        CH_GREEN: begin
          acc[CH_GREEN] <= acc[CH_GREEN] + tap_val; cnt[CH_GREEN] <= cnt[CH_GREEN] + CNT_W'(1);
        end
        CH_BLUE: begin
          acc[CH_BLUE] <= acc[CH_BLUE] + tap_val; cnt[CH_BLUE] <= cnt[CH_BLUE] + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // per-channel source selection, gain multiply, divide
  logic [ACC_W-1:0]  sel_acc;
  logic [GAIN_W-1:0] sel_gain;
  logic [CNT_W-1:0]  sel_cnt, gc;
  logic              sel_sh3, sel_zero;
  logic [PROD_W-1:0] prod;
  logic              prod_sh3, prod_zero;
  logic [CNT_W-1:0]  prod_cnt;
  logic [DIVD_W-1:0] div_q;
  logic [SAMPLE_W-1:0] res [3];

  assign gc = (cnt[1] != '0) ? cnt[1] : CNT_W'(1);

  always_comb begin
    sel_acc  = acc[1];
    sel_gain = gain_green;
    sel_cnt  = gc;
    sel_sh3  = 1'b1;
    sel_zero = 1'b0;
    case (cmd.chan)
      CH_RED: begin
        sel_gain = gain_red;
        if (cnt[0] != '0) begin
          sel_acc = acc[0]; sel_cnt = cnt[0];
        end else begin
          sel_sh3 = 1'b0;
        end
      end
      CH_BLUE: begin
        sel_gain = gain_blue;
        if (cnt[2] != '0) begin
          sel_acc = acc[2]; sel_cnt = cnt[2];
        end else begin
          sel_sh3 = 1'b0;
        end
      end
      CH_GREEN: begin
        if (cnt[1] != '0) begin
          sel_acc = acc[1]; sel_cnt = cnt[1];
        end else if (cnt[0] != '0) begin
          sel_acc = acc[0]; sel_cnt = cnt[0];
        end else if (cnt[2] != '0) begin
          sel_acc = acc[2]; sel_cnt = cnt[2];
        end else begin
          sel_zero = 1'b1;
        end
      end
      default: sel_zero = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod      <= PROD_W'(sel_acc) * PROD_W'(sel_gain);
      prod_sh3  <= sel_sh3;
      prod_zero <= sel_zero;
      prod_cnt  <= sel_cnt;
    end
  end

  bwd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_sh3 ? DIVD_W'(prod >> 19) : DIVD_W'(prod >> 18)),
    .divisor  (prod_cnt),
    .quotient (div_q),
    .done     (div_fin)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_store) begin
      if (prod_zero) res[cmd.chan] <= '0;
      else if (div_q > DIVD_W'(65535)) res[cmd.chan] <= '1;
      else res[cmd.chan] <= div_q[SAMPLE_W-1:0];
    end
    if (cmd.out_load) begin
      red       <= res[CH_RED];
      green     <= res[CH_GREEN];
      blue      <= res[CH_BLUE];
      row_end   <= (pos_x == ow - CPW'(1));
      frame_end <= (pos_x == ow - CPW'(1)) && (pos_y == oh - RPW'(1));
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bayer_window_demosaic.sv =====
// Top level of the Bayer window demosaic: channels, controller and datapath.
// Depends on bwd_pkg, bwd_if, bwd_ctrl, bwd_dp (and through it bwd_ram, bwd_div).
//
// Usage:
//  - samples: raw mosaic words in raster order over a grid of (width+2) x
//    (height+2); padding words are taken and ignored.
//  - pixels: one RGB word per grid position that maps to an output pixel,
//    two rows up and two columns left of the sample just taken; row_end and
//    frame_end mark the last pixel of a row and of the frame.
//  - cfg: register writes (index, data), always ready; write only while idle.
// Timing: one sample at a time. A padding or non-output position goes
//  through accept, 4 line-store reads, write and window shift. An output
//  position adds 25 tap accumulations, then for each of 3 channels a
//  multiply, divider start and a 28-step divide, and one output load.
//  The shared bit-serial divider dominates the time per pixel.
// Stall: a finished pixel sits in the output register; the next sample is
//  taken meanwhile, and the block holds before loading another pixel.
// Reset: synchronous; position goes to the grid origin and registers to
//  their defaults. The line store is not cleared: the first rows of a frame
//  are written before any tap reads them.
`default_nettype none
module bayer_window_demosaic #(
  parameter int MAX_WIDTH  = bwd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bwd_pkg::DEF_MAX_HEIGHT
) (
  input wire logic  clk,
  input wire logic  rst,
  bwd_in_if.sink    samples,
  bwd_out_if.source pixels,
  bwd_cfg_if.sink   cfg
);
  import bwd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  // configuration is taken in any cycle
  assign cfg.ready = 1'b1;

  bwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bwd_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .sample    (samples.sample),
    .cmd       (cmd),
    .stat      (stat),
    .red       (pixels.red),
    .green     (pixels.green),
    .blue      (pixels.blue),
    .row_end   (pixels.row_end),
    .frame_end (pixels.frame_end)
  );
endmodule
`default_nettype wire

// ===== sim/tb_bayer_window_demosaic.sv =====
// Self-checking testbench for bayer_window_demosaic: frames of raw samples
// checked pixel by pixel against a demosaic predictor kept in the bench.
// Depends on bwd_pkg, bwd_if and the block's RTL.
`default_nettype none
module tb_bayer_window_demosaic;
  timeunit 1ns;
  timeprecision 1ps;
  import bwd_pkg::*;

  localparam int  LINE_MAX   = 8192;
  localparam int  DRAIN_CYC  = 400;      // several pixel times past the last word
  localparam int  LIMIT_CYC  = 3000000;
  localparam int  HOLD_CYC   = 900;      // long receiver hold-off

  // how a frame's samples are made
  typedef enum logic [1:0] {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_CHECKER} fill_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        row_end;
    logic        frame_end;
  } pixel_t;

  typedef struct {
    logic [1:0]  pattern;
    logic [13:0] mw, mh, ow, oh;
    logic [23:0] gr, gg, gb;
    fill_t       fill;
    bit          gains_off;   // all gains zero: every colour reads zero
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bwd_in_if  sin();
  bwd_out_if sout();
  bwd_cfg_if scfg();

  bayer_window_demosaic dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sin),
    .pixels  (sout),
    .cfg     (scfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copy, four stored mosaic rows, 5x5 window, position
  // ---------------------------------------------------------------------------
  logic [1:0]  cfg_pattern;
  logic [13:0] cfg_mw, cfg_mh, cfg_ow, cfg_oh;
  logic [23:0] cfg_gr, cfg_gg, cfg_gb;
  logic [15:0] line_store [4][LINE_MAX];
  logic [15:0] win [5][5];
  int unsigned pos_row, pos_col;

  pixel_t pending_pixels[$];
  int     errors = 0;
  int     cyc = 0;
  int     items_sent = 0;
  int     pixels_seen = 0;
  bit     calm = 1'b0;       // no idling on either side while set
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [15:0] gain_scale(longint unsigned sum, longint unsigned gain,
                                             longint unsigned div);
    longint unsigned v;
    v = (sum * gain) / (div * 65536);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // advance the demosaic predictor by one sample word; returns 1 with a pixel
  function automatic bit demosaic_step(input logic [15:0] s, output pixel_t px);
    int unsigned mw, mh, ow, oh, gw, gh, r, c, y, x, yy, xx, w, col;
    int unsigned acc[3], cnt[3], gc;
    logic [15:0] v;
    px = '0;
    mw = clamp_dim(cfg_mw, LINE_MAX);
    mh = clamp_dim(cfg_mh, LINE_MAX);
    ow = clamp_dim(cfg_ow, 16383);
    oh = clamp_dim(cfg_oh, 16383);
    if (ow > mw) ow = mw;
    if (oh > mh) oh = mh;
    gw = mw + 2;
    gh = mh + 2;
    if (pos_col >= gw) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= gh) pos_row = 0;
    r = pos_row;
    c = pos_col;
    for (int dy = 0; dy < 5; dy++)
      for (int dx = 0; dx < 4; dx++)
        win[dy][dx] = win[dy][dx+1];
    for (int k = 0; k < 4; k++) begin
      v = '0;
      if (c < mw && r + k >= 4) v = line_store[(r + k - 4) & 3][c];
      win[k][4] = v;
    end
    win[4][4] = (r < mh && c < mw) ? s : 16'd0;
    if (r < mh && c < mw) line_store[r & 3][c] = s;

    demosaic_step = 1'b0;
    if (r >= 2 && c >= 2 && r - 2 < oh && c - 2 < ow) begin
      y = r - 2;
      x = c - 2;
      acc = '{0, 0, 0};
      cnt = '{0, 0, 0};
      for (int dy = 0; dy < 5; dy++) begin
        yy = y + dy;
        if (yy < 2 || yy - 2 >= mh) continue;
        for (int dx = 0; dx < 5; dx++) begin
          xx = x + dx;
          if (xx < 2 || xx - 2 >= mw) continue;
          col = COLOUR_TABLE[cfg_pattern][{(yy - 2) % 2 == 1, (xx - 2) % 2 == 1}];
          // centre 16, the four nearest orthogonal taps 4, everything else 1
          if (dy == 2 && dx == 2) w = 16;
          else if ((dy == 2 && (dx == 1 || dx == 3)) || (dx == 2 && (dy == 1 || dy == 3)))
            w = 4;
          else w = 1;
          acc[col] += win[dy][dx] * w;
          cnt[col]++;
        end
      end
      gc = (cnt[CH_GREEN] != 0) ? cnt[CH_GREEN] : 1;
      px.red  = (cnt[CH_RED] != 0) ? gain_scale(acc[CH_RED], cfg_gr, 8 * cnt[CH_RED])
                                   : gain_scale(acc[CH_GREEN], cfg_gr, 4 * gc);
      px.blue = (cnt[CH_BLUE] != 0) ? gain_scale(acc[CH_BLUE], cfg_gb, 8 * cnt[CH_BLUE])
                                    : gain_scale(acc[CH_GREEN], cfg_gb, 4 * gc);
      // missing green borrows red, else blue; neither leaves it zero
      if (cnt[CH_GREEN] != 0)
        px.green = gain_scale(acc[CH_GREEN], cfg_gg, 8 * cnt[CH_GREEN]);
      else if (cnt[CH_RED] != 0)
        px.green = gain_scale(acc[CH_RED], cfg_gg, 8 * cnt[CH_RED]);
      else if (cnt[CH_BLUE] != 0)
        px.green = gain_scale(acc[CH_BLUE], cfg_gg, 8 * cnt[CH_BLUE]);
      else
        px.green = '0;
      px.row_end   = (x == ow - 1);
      px.frame_end = (x == ow - 1 && y == oh - 1);
      demosaic_step = 1'b1;
    end

    pos_col = c + 1;
    if (pos_col >= gw) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= gh) pos_row = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs move on the falling edge, handshakes are seen on the rising
  // ---------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_t idx, input logic [23:0] data);
    @(negedge clk);
    scfg.valid = 1'b1;
    scfg.index = idx;
    scfg.data  = data;
    do @(posedge clk); while (!scfg.ready);
    case (idx)
      REG_PATTERN:    cfg_pattern = data[1:0];
      REG_MOS_WIDTH:  cfg_mw      = data[13:0];
      REG_MOS_HEIGHT: cfg_mh      = data[13:0];
      REG_OUT_WIDTH:  cfg_ow      = data[13:0];
      REG_OUT_HEIGHT: cfg_oh      = data[13:0];
      REG_GAIN_RED:   cfg_gr      = data;
      REG_GAIN_GREEN: cfg_gg      = data;
      REG_GAIN_BLUE:  cfg_gb      = data;
      default: ;
    endcase
    @(negedge clk);
    scfg.valid = 1'b0;
  endtask

  // offer one sample word; valid stays high into the next word when no gap follows
  task automatic send_sample(input logic [15:0] s, input bit zero_colours);
    pixel_t px;
    while (!calm && $urandom_range(99) < 13) begin
      sin.valid = 1'b0;
      @(negedge clk);
    end
    sin.valid  = 1'b1;
    sin.sample = s;
    do @(posedge clk); while (!sin.ready);
    items_sent++;
    if (demosaic_step(s, px)) begin
      if (zero_colours) begin
        px.red   = '0;
        px.green = '0;
        px.blue  = '0;
      end
      pending_pixels.push_back(px);
    end
    @(negedge clk);
  endtask

  // block is idle once every pixel is back and the trailing padding has drained
  task automatic wait_idle();
    sin.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic run_frame(input frame_t f);
    int unsigned gw, gh, n;
    logic [15:0] s;
    write_reg(REG_PATTERN,    {22'd0, f.pattern});
    write_reg(REG_MOS_WIDTH,  {10'd0, f.mw});
    write_reg(REG_MOS_HEIGHT, {10'd0, f.mh});
    write_reg(REG_OUT_WIDTH,  {10'd0, f.ow});
    write_reg(REG_OUT_HEIGHT, {10'd0, f.oh});
    write_reg(REG_GAIN_RED,   f.gr);
    write_reg(REG_GAIN_GREEN, f.gg);
    write_reg(REG_GAIN_BLUE,  f.gb);
    gw = clamp_dim(f.mw, LINE_MAX) + 2;
    gh = clamp_dim(f.mh, LINE_MAX) + 2;
    n = 0;
    for (int r = 0; r < gh; r++)
      for (int c = 0; c < gw; c++) begin
        case (f.fill)
          FILL_MAX:     s = 16'hFFFF;
          FILL_ZERO:    s = 16'h0000;
          FILL_CHECKER: s = ((r + c) % 2 == 1) ? 16'hFFFF : 16'h0000;
          default:      s = ($urandom_range(9) == 0) ? {16{$urandom_range(1) == 1}}
                                                     : 16'($urandom);
        endcase
        send_sample(s, f.gains_off);
        n++;
      end
    wait_idle();
  endtask

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(5))
      0:       return 24'hFFFFFF;
      1:       return 24'd0;
      2:       return 24'h010000;
      default: return 24'($urandom_range(24'h03FFFF));
    endcase
  endfunction

  // directed frames: tiny mosaic, output larger than mosaic with saturation,
  // zero gains, every pattern and clamped sizes
  frame_t directed [6] = '{
    '{2'd0, 14'd1,     14'd1, 14'd1,     14'd1,     24'h010000, 24'h010000, 24'h010000,
      FILL_MAX, 1'b0},
    '{2'd1, 14'd2,     14'd2, 14'd5,     14'd5,     24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
      FILL_MAX, 1'b0},
    '{2'd2, 14'd3,     14'd2, 14'd2,     14'd1,     24'd0,      24'd0,      24'd0,
      FILL_RANDOM, 1'b1},
    '{2'd3, 14'd2,     14'd3, 14'd2,     14'd3,     24'h008000, 24'h020000, 24'h00C000,
      FILL_CHECKER, 1'b0},
    '{2'd0, 14'd0,     14'd2, 14'd0,     14'd16383, 24'h010000, 24'h010000, 24'h010000,
      FILL_ZERO, 1'b0},
    '{2'd1, 14'd9,     14'd0, 14'd2,     14'd16383, 24'h010000, 24'hFFFFFF, 24'd1,
      FILL_RANDOM, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Receiver: random ready, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    sout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        sout.ready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_done = 1'b1;
      end
      sout.ready = calm || ($urandom_range(99) >= 13);
    end
  end

  // pixel checker
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && sout.valid && sout.ready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel r=%h g=%h b=%h", $time, sout.red, sout.green,
                 sout.blue);
      end else begin
        want = pending_pixels.pop_front();
        if (sout.red !== want.red || sout.green !== want.green || sout.blue !== want.blue ||
            sout.row_end !== want.row_end || sout.frame_end !== want.frame_end) begin
          errors++;
          $display("%0t: pixel mismatch exp r=%h g=%h b=%h re=%b fe=%b", $time, want.red,
                   want.green, want.blue, want.row_end, want.frame_end);
          $display("%0t:                got r=%h g=%h b=%h re=%b fe=%b", $time, sout.red,
                   sout.green, sout.blue, sout.row_end, sout.frame_end);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    calm <= (cyc % 20000) < 3000;
    if (cyc > LIMIT_CYC) begin
      $display("[bayer_window_demosaic] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    frame_t f;
    int     frames;
    sin.valid   = 1'b0;
    sin.sample  = '0;
    scfg.valid  = 1'b0;
    scfg.index  = REG_PATTERN;
    scfg.data   = '0;
    cfg_pattern = 2'd0;
    cfg_mw = 14'd8192; cfg_mh = 14'd8192; cfg_ow = 14'd8192; cfg_oh = 14'd8192;
    cfg_gr = 24'h010000; cfg_gg = 24'h010000; cfg_gb = 24'h010000;
    pos_row = 0;
    pos_col = 0;
    foreach (win[i, j]) win[i][j] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) run_frame(directed[i]);

    // random frames, mostly small; the receiver stalls for a long stretch in one
    frames = 0;
    while (items_sent < 400 || pixels_seen < 60) begin
      f.pattern   = 2'($urandom_range(3));
      f.mw        = 14'($urandom_range(1, 8));
      f.mh        = 14'($urandom_range(1, 6));
      f.ow        = 14'($urandom_range(0, 10));
      f.oh        = 14'($urandom_range(0, 8));
      f.gr        = pick_gain();
      f.gg        = pick_gain();
      f.gb        = pick_gain();
      f.fill      = ($urandom_range(7) == 0) ? FILL_CHECKER : FILL_RANDOM;
      f.gains_off = 1'b0;
      if (frames == 2) begin
        f.mw = 14'd8; f.mh = 14'd6; f.ow = 14'd8; f.oh = 14'd6;
        hold_req = 1'b1;
      end
      run_frame(f);
      frames++;
    end

    wait_idle();
    if (errors == 0)
      $display("[bayer_window_demosaic] OK");
    else
      $display("[bayer_window_demosaic] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
